// ===== design/ppfc_pkg.sv =====
// shared types, widths and constants for the pump pi flow controller
// no dependencies
package ppfc_pkg;

  localparam int PWM_BITS       = 8;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int FLOW_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 18;
  localparam int ERR_W   = FLOW_W + 1;
  localparam int INTEG_W = LIM_W + 1;
  localparam int SUM_W   = INTEG_W + 1;
  localparam int PP_W    = GAIN_W + 1 + ERR_W;
  localparam int PI_W    = GAIN_W + 1 + SUM_W;
  localparam int TOT_W   = PI_W + 1;
  localparam int DRV_SHIFT = GAIN_FRAC_BITS + 8;
  localparam int WHOLE_W = TOT_W - DRV_SHIFT;

  localparam logic [PWM_BITS-1:0] PWM_MAX = '1;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_KP    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT = 2'd2;

  localparam logic [GAIN_W-1:0] KP_RESET    = 16'd410;
  localparam logic [GAIN_W-1:0] KI_RESET    = 16'd4096;
  localparam logic [LIM_W-1:0]  LIMIT_RESET = 18'd256000;

  typedef enum logic [1:0] {
    OP_STEP   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_MANUAL = 2'd3
  } op_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [LIM_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    op_e                      op;
    logic [PWM_BITS-1:0]      manual;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic                     running;
  } s1_t;

  typedef struct packed {
    op_e                      op;
    logic [PWM_BITS-1:0]      manual;
    logic signed [ERR_W-1:0]  err;
    logic signed [PP_W-1:0]   prod_p;
    logic signed [PI_W-1:0]   prod_i;
    logic                     running;
  } s2_t;

endpackage

// ===== design/ppfc_cfg.sv =====
// gain and integrator limit registers behind the apb-style port
// depends on ppfc_pkg
module ppfc_cfg import ppfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t                 cfg_q;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp    <= KP_RESET;
      cfg_q.ki    <= KI_RESET;
      cfg_q.limit <= LIMIT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_KP:    cfg_q.kp    <= pwdata[GAIN_W-1:0];
        REG_KI:    cfg_q.ki    <= pwdata[GAIN_W-1:0];
        REG_LIMIT: cfg_q.limit <= pwdata[LIM_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:    prdata = CFG_DATA_W'(cfg_q.kp);
      REG_KI:    prdata = CFG_DATA_W'(cfg_q.ki);
      REG_LIMIT: prdata = CFG_DATA_W'(cfg_q.limit);
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== design/ppfc_front.sv =====
// input register, error and integrator stage with clamp and run state
// depends on ppfc_pkg
module ppfc_front import ppfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [FLOW_W-1:0]   target_flow_i,
  input  logic [FLOW_W-1:0]   measured_flow_i,
  input  logic [PWM_BITS-1:0] manual_duty_i,
  output logic                s1_valid_o,
  input  logic                s1_ready_i,
  output s1_t                 s1_o
);

  logic                      in_valid_q;
  op_e                       op_q;
  logic [FLOW_W-1:0]         tgt_q;
  logic [FLOW_W-1:0]         meas_q;
  logic [PWM_BITS-1:0]       man_q;

  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]   last_err_q, last_err_d;
  logic                      run_q, run_d;

  logic                      s1_valid_q;
  s1_t                       s1_q, s1_d;

  logic                      en_s1, fire;
  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W-1:0]   sum, lim_s, nlim_s, clamp;

  assign en_s1      = !s1_valid_q || s1_ready_i;
  assign fire       = in_valid_q && en_s1;
  assign in_ready_o = !in_valid_q || en_s1;
  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

  assign err    = signed'({1'b0, tgt_q}) - signed'({1'b0, meas_q});
  assign sum    = SUM_W'(integ_q) + SUM_W'(err);
  assign lim_s  = signed'({{(SUM_W-LIM_W){1'b0}}, cfg_i.limit});
  assign nlim_s = -lim_s;

  always_comb begin
    if (sum > lim_s) begin
      clamp = lim_s;
    end else if (sum < nlim_s) begin
      clamp = nlim_s;
    end else begin
      clamp = sum;
    end

    integ_d    = integ_q;
    last_err_d = last_err_q;
    run_d      = run_q;
    case (op_q)
      OP_STEP: begin
        integ_d    = clamp[INTEG_W-1:0];
        last_err_d = err;
      end
      OP_START: run_d = 1'b1;
      OP_STOP:  run_d = 1'b0;
      default:  ;
    endcase

    s1_d.op      = op_q;
    s1_d.manual  = man_q;
    s1_d.err     = last_err_d;
    s1_d.sum     = sum;
    s1_d.running = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      integ_q    <= '0;
      last_err_q <= '0;
      run_q      <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (en_s1) begin
        s1_valid_q <= in_valid_q;
      end
      if (fire) begin
        integ_q    <= integ_d;
        last_err_q <= last_err_d;
        run_q      <= run_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_e'(operation_i);
      tgt_q  <= target_flow_i;
      meas_q <= measured_flow_i;
      man_q  <= manual_duty_i;
    end
    if (fire) begin
      s1_q <= s1_d;
    end
  end

endmodule

// ===== design/ppfc_mul.sv =====
// gain multiply stage: kp times error and ki times unclamped integrator
// depends on ppfc_pkg
module ppfc_mul import ppfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic s1_valid_i,
  output logic s1_ready_o,
  input  s1_t  s1_i,
  output logic s2_valid_o,
  input  logic s2_ready_i,
  output s2_t  s2_o
);

  logic                     s2_valid_q;
  s2_t                      s2_q, s2_d;
  logic                     en;
  logic signed [GAIN_W:0]   kp_s, ki_s;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PI_W-1:0]   prod_i;

  assign en         = !s2_valid_q || s2_ready_i;
  assign s1_ready_o = en;
  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

  assign kp_s   = signed'({1'b0, cfg_i.kp});
  assign ki_s   = signed'({1'b0, cfg_i.ki});
  assign prod_p = kp_s * s1_i.err;
  assign prod_i = ki_s * s1_i.sum;

  always_comb begin
    s2_d.op      = s1_i.op;
    s2_d.manual  = s1_i.manual;
    s2_d.err     = s1_i.err;
    s2_d.prod_p  = prod_p;
    s2_d.prod_i  = prod_i;
    s2_d.running = s1_i.running;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && en) begin
      s2_q <= s2_d;
    end
  end

endmodule

// ===== design/ppfc_back.sv =====
// drive sum and saturation, stored duty and the result register
// depends on ppfc_pkg
module ppfc_back import ppfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s2_valid_i,
  output logic                s2_ready_o,
  input  s2_t                 s2_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PWM_BITS-1:0] pwm_duty_o,
  output logic [PWM_BITS-1:0] duty_setting_o,
  output logic                running_o,
  output logic [ERR_W-1:0]    flow_error_o
);

  logic                     out_valid_q;
  logic [PWM_BITS-1:0]      duty_q, duty_d;
  logic [PWM_BITS-1:0]      pwm_q, setting_q;
  logic                     run_q;
  logic [ERR_W-1:0]         err_q;
  logic                     en, fire;
  logic signed [TOT_W-1:0]  total;
  logic [WHOLE_W-1:0]       whole;
  logic [PWM_BITS-1:0]      drive;

  assign en          = !out_valid_q || out_ready_i;
  assign fire        = s2_valid_i && en;
  assign s2_ready_o  = en;
  assign out_valid_o = out_valid_q;

  assign total = TOT_W'(s2_i.prod_p) + TOT_W'(s2_i.prod_i);
  assign whole = total[TOT_W-1:DRV_SHIFT];

  always_comb begin
    if (total[TOT_W-1]) begin
      drive = '0;
    end else if (whole > WHOLE_W'(PWM_MAX)) begin
      drive = PWM_MAX;
    end else begin
      drive = whole[PWM_BITS-1:0];
    end

    case (s2_i.op)
      OP_STEP:   duty_d = PWM_MAX - drive;
      OP_MANUAL: duty_d = s2_i.manual;
      default:   duty_d = duty_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      duty_q      <= '0;
    end else begin
      if (en) begin
        out_valid_q <= s2_valid_i;
      end
      if (fire) begin
        duty_q <= duty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pwm_q     <= s2_i.running ? duty_d : '0;
      setting_q <= duty_d;
      run_q     <= s2_i.running;
      err_q     <= s2_i.err;
    end
  end

  assign pwm_duty_o     = pwm_q;
  assign duty_setting_o = setting_q;
  assign running_o      = run_q;
  assign flow_error_o   = err_q;

endmodule

// ===== design/pump_pi_flow_controller.sv =====
// top level of the pump pi flow controller: config port and front, multiply and back pipeline stages
// depends on ppfc_pkg, ppfc_cfg, ppfc_front, ppfc_mul, ppfc_back
//
// accepts one item per cycle unless the output stalls and gives one result per item via
// input, s1, s2 and result registers; the integrator and run state live in the first stage,
// so back-to-back control steps see each other's update. the user writes gains and integrator
// limit over the apb-style port only while the pipeline is empty; the block does not enforce it
module pump_pi_flow_controller import ppfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            operation_i,
  input  logic [FLOW_W-1:0]     target_flow_i,
  input  logic [FLOW_W-1:0]     measured_flow_i,
  input  logic [PWM_BITS-1:0]   manual_duty_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PWM_BITS-1:0]   pwm_duty_o,
  output logic [PWM_BITS-1:0]   duty_setting_o,
  output logic                  running_o,
  output logic [ERR_W-1:0]      flow_error_o
);

  cfg_t cfg;
  logic s1_valid, s1_ready, s2_valid, s2_ready;
  s1_t  s1;
  s2_t  s2;

  ppfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppfc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .target_flow_i   (target_flow_i),
    .measured_flow_i (measured_flow_i),
    .manual_duty_i   (manual_duty_i),
    .s1_valid_o      (s1_valid),
    .s1_ready_i      (s1_ready),
    .s1_o            (s1)
  );

  ppfc_mul u_mul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_i       (s1),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_o       (s2)
  );

  ppfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s2_valid_i     (s2_valid),
    .s2_ready_o     (s2_ready),
    .s2_i           (s2),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pwm_duty_o     (pwm_duty_o),
    .duty_setting_o (duty_setting_o),
    .running_o      (running_o),
    .flow_error_o   (flow_error_o)
  );

  // stopped pump drives no pwm
  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_o |-> pwm_duty_o == '0)
    else $error("pwm nonzero while stopped");

  // running pump drives the stored duty
  a_running_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && running_o |-> pwm_duty_o == duty_setting_o)
    else $error("pwm differs from stored duty while running");

  // a taken result frees the whole pipeline for a new beat
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

endmodule
